// ----- rtl/swtc_pkg.sv -----
// ----------------------------------------------------------------------------
// swtc_pkg
// Shared constants, control word type and microcode ROM for the SJF
// wait/turnaround calculator.
// ----------------------------------------------------------------------------
package swtc_pkg;

  localparam int unsigned MaxProcs = 32;
  localparam int unsigned BurstW   = 16;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned TimeW    = 21;
  localparam int unsigned PcW      = 4;

  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PcLoad   = 4'd0;
  localparam pc_t PcIZero  = 4'd1;
  localparam pc_t PcOuter  = 4'd2;
  localparam pc_t PcCur    = 4'd3;
  localparam pc_t PcInner  = 4'd4;
  localparam pc_t PcWbi    = 4'd5;
  localparam pc_t PcAZero  = 4'd6;
  localparam pc_t PcARead  = 4'd7;
  localparam pc_t PcAWr    = 4'd8;
  localparam pc_t PcOZero  = 4'd9;
  localparam pc_t PcORead  = 4'd10;
  localparam pc_t PcOSend  = 4'd11;
  localparam pc_t PcDone   = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_IZERO,
    OP_OUTER,
    OP_CUR,
    OP_INNER,
    OP_WBI,
    OP_AZERO,
    OP_AWR,
    OP_OSEND,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LAST,
    C_SORTED,
    C_JMORE,
    C_IMORE
  } cond_e;

  typedef enum logic [1:0] {
    RD_I,
    RD_J,
    RD_JN
  } rd_sel_e;

  typedef struct packed {
    logic    in_rdy;
    logic    wait_in;
    logic    wait_out;
    op_e     op;
    rd_sel_e rd;
    cond_e   cond;
    pc_t     tgt;
  } ctrl_t;

  // taken jump goes to tgt, otherwise pc + 1; wait_* holds pc while its stream is not ready
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    c = '{in_rdy: 1'b0, wait_in: 1'b0, wait_out: 1'b0, op: OP_NONE,
          rd: RD_I, cond: C_NEVER, tgt: PcLoad};
    unique case (pc)
      PcLoad: begin
        c.in_rdy  = 1'b1;
        c.wait_in = 1'b1;
        c.op      = OP_LOAD;
        c.cond    = C_NOT_LAST;
        c.tgt     = PcLoad;
      end
      PcIZero: begin
        c.op = OP_IZERO;
      end
      PcOuter: begin
        c.op   = OP_OUTER;
        c.rd   = RD_I;
        c.cond = C_SORTED;
        c.tgt  = PcAZero;
      end
      PcCur: begin
        c.op = OP_CUR;
        c.rd = RD_J;
      end
      PcInner: begin
        c.op   = OP_INNER;
        c.rd   = RD_JN;
        c.cond = C_JMORE;
        c.tgt  = PcInner;
      end
      PcWbi: begin
        c.op   = OP_WBI;
        c.rd   = RD_I;
        c.cond = C_ALWAYS;
        c.tgt  = PcOuter;
      end
      PcAZero: begin
        c.op = OP_AZERO;
      end
      PcARead: begin
        c.rd = RD_I;
      end
      PcAWr: begin
        c.op   = OP_AWR;
        c.cond = C_IMORE;
        c.tgt  = PcARead;
      end
      PcOZero: begin
        c.op = OP_IZERO;
      end
      PcORead: begin
        c.op = OP_NONE;
      end
      PcOSend: begin
        c.wait_out = 1'b1;
        c.op       = OP_OSEND;
        c.cond     = C_IMORE;
        c.tgt      = PcORead;
      end
      PcDone: begin
        c.op   = OP_DONE;
        c.cond = C_ALWAYS;
        c.tgt  = PcLoad;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.tgt  = PcLoad;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/sjf_wait_turnaround_calc_top.sv -----
// ----------------------------------------------------------------------------
// sjf_wait_turnaround_calc_top
// Non-preemptive shortest-job-first wait and turnaround calculator.
// ----------------------------------------------------------------------------
// Load one burst per input word; the word with tlast closes the batch (words
// beyond MAX_PROCS are dropped, but tlast still closes). The batch is ordered
// by an exchange sort over a sort RAM with one write and one read port, start
// times are summed, and one result word per process comes out in load order,
// tlast on the final one. A batch passes through load, sort (one compare per
// cycle through the sort RAM read port), accumulation and output, and the
// output waits while the sink stalls. A new batch is taken while the last
// result waits.
// ----------------------------------------------------------------------------
module sjf_wait_turnaround_calc_top #(
  parameter int unsigned MAX_PROCS = swtc_pkg::MaxProcs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] burst_time
  input  logic        s_axis_tlast,   // last_process
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [4:0] process_index, [25:5] wait_time,
                                      // [46:26] turnaround_time, [47] zero
  output logic        m_axis_tlast    // last_result
);

  localparam int unsigned IW  = $clog2(MAX_PROCS);
  localparam int unsigned CW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned BW  = swtc_pkg::BurstW;
  localparam int unsigned TW  = swtc_pkg::TimeW;
  localparam int unsigned OW  = swtc_pkg::IdxW;
  localparam int unsigned SW  = BW + IW;

  swtc_pkg::pc_t   pc_q, pc_d;
  swtc_pkg::ctrl_t ctrl;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [TW-1:0] acc_q, acc_d;
  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] out_idx_q;
  logic [TW-1:0] out_wait_q;
  logic [TW-1:0] out_ta_q;
  logic          out_last_q;

  logic          in_acc;
  logic          can_send;
  logic          stall;
  logic          cond_ok;
  logic [CW:0]   i_inc;
  logic [CW:0]   j_inc;
  logic [31:0]   i_ext;

  logic          sort_we;
  logic [IW-1:0] sort_waddr;
  logic [SW-1:0] sort_wdata;
  logic [IW-1:0] sort_raddr;
  logic [SW-1:0] sort_rdata;
  logic          burst_we;
  logic [BW-1:0] burst_rdata;
  logic          wait_we;
  logic [TW-1:0] wait_rdata;
  logic          swap;

  assign ctrl          = swtc_pkg::ucode(pc_q);
  assign s_axis_tready = ctrl.in_rdy;
  assign in_acc        = s_axis_tvalid && ctrl.in_rdy;
  assign can_send      = !out_valid_q || m_axis_tready;
  assign i_inc         = {1'b0, i_q} + 1'b1;
  assign j_inc         = {1'b0, j_q} + 1'b1;
  assign i_ext         = 32'(i_q);
  assign swap          = cur_q[SW-1 -: BW] > sort_rdata[SW-1 -: BW];
  assign stall         = (ctrl.wait_in && !in_acc) || (ctrl.wait_out && !can_send);

  always_comb begin
    case (ctrl.cond)
      swtc_pkg::C_ALWAYS:   cond_ok = 1'b1;
      swtc_pkg::C_NOT_LAST: cond_ok = !s_axis_tlast;
      swtc_pkg::C_SORTED:   cond_ok = i_inc >= {1'b0, cnt_q};
      swtc_pkg::C_JMORE:    cond_ok = j_inc < {1'b0, cnt_q};
      swtc_pkg::C_IMORE:    cond_ok = i_inc < {1'b0, cnt_q};
      default:              cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.rd)
      swtc_pkg::RD_J:  sort_raddr = j_q[IW-1:0];
      swtc_pkg::RD_JN: sort_raddr = j_inc[IW-1:0];
      default:         sort_raddr = i_q[IW-1:0];
    endcase
  end

  always_comb begin
    pc_d        = stall ? pc_q : (cond_ok ? ctrl.tgt : pc_q + 1'b1);
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    sort_we     = 1'b0;
    sort_waddr  = i_q[IW-1:0];
    sort_wdata  = cur_q;
    burst_we    = 1'b0;
    wait_we     = 1'b0;
    unique case (ctrl.op)
      swtc_pkg::OP_LOAD: begin
        if (in_acc && (cnt_q < CW'(MAX_PROCS))) begin
          sort_we    = 1'b1;
          burst_we   = 1'b1;
          sort_waddr = cnt_q[IW-1:0];
          sort_wdata = {s_axis_tdata, cnt_q[IW-1:0]};
          cnt_d      = cnt_q + 1'b1;
        end
      end
      swtc_pkg::OP_IZERO: begin
        i_d = '0;
      end
      swtc_pkg::OP_OUTER: begin
        j_d = i_inc[CW-1:0];
      end
      swtc_pkg::OP_CUR: begin
        cur_d = sort_rdata;
      end
      swtc_pkg::OP_INNER: begin
        if (swap) begin
          sort_we    = 1'b1;
          sort_waddr = j_q[IW-1:0];
          cur_d      = sort_rdata;
        end
        j_d = j_inc[CW-1:0];
      end
      swtc_pkg::OP_WBI: begin
        sort_we = 1'b1;
        i_d     = i_inc[CW-1:0];
      end
      swtc_pkg::OP_AZERO: begin
        i_d   = '0;
        acc_d = '0;
      end
      swtc_pkg::OP_AWR: begin
        wait_we = 1'b1;
        acc_d   = acc_q + TW'(sort_rdata[SW-1 -: BW]);
        i_d     = i_inc[CW-1:0];
      end
      swtc_pkg::OP_OSEND: begin
        if (can_send) begin
          out_valid_d = 1'b1;
          i_d         = i_inc[CW-1:0];
        end
      end
      swtc_pkg::OP_DONE: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= swtc_pkg::PcLoad;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    acc_q <= acc_d;
    if (ctrl.op == swtc_pkg::OP_OSEND && can_send) begin
      out_idx_q  <= i_ext[OW-1:0];
      out_wait_q <= wait_rdata;
      out_ta_q   <= wait_rdata + TW'(burst_rdata);
      out_last_q <= i_inc == {1'b0, cnt_q};
    end
  end

  // sort entries: {burst, load index}
  swtc_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_PROCS)
  ) u_sort_ram (
    .clk_i  (clk_i),
    .we_i   (sort_we),
    .waddr_i(sort_waddr),
    .wdata_i(sort_wdata),
    .raddr_i(sort_raddr),
    .rdata_o(sort_rdata)
  );

  swtc_ram #(
    .WIDTH(BW),
    .DEPTH(MAX_PROCS)
  ) u_burst_ram (
    .clk_i  (clk_i),
    .we_i   (burst_we),
    .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(s_axis_tdata),
    .raddr_i(i_q[IW-1:0]),
    .rdata_o(burst_rdata)
  );

  swtc_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_PROCS)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (wait_we),
    .waddr_i(sort_rdata[IW-1:0]),
    .wdata_i(acc_q),
    .raddr_i(i_q[IW-1:0]),
    .rdata_o(wait_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_ta_q, out_wait_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/swtc_ram.sv -----
// ----------------------------------------------------------------------------
// swtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swtc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/sjf_wait_turnaround_calc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_wait_turnaround_calc_checker
// Watches both stream channels of the SJF calculator. It rebuilds every batch
// from the accepted input words, orders it shortest job first with an exchange
// sort, sums start times and queues the expected wait and turnaround words.
// Each output word is then compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module sjf_wait_turnaround_calc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [swtc_pkg::IdxW-1:0]  proc_idx;
    logic [swtc_pkg::TimeW-1:0] wait_tm;
    logic [swtc_pkg::TimeW-1:0] turnaround;
    logic                       last_res;
  } proc_times_t;

  logic [swtc_pkg::BurstW-1:0] batch_bursts [swtc_pkg::MaxProcs];
  int unsigned                 batch_len;
  proc_times_t                 sched_times_q [$];
  int unsigned                 fails   = 0;
  int unsigned                 pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic void schedule_batch_times();
    int unsigned                run_order [swtc_pkg::MaxProcs];
    logic [swtc_pkg::TimeW-1:0] start_at  [swtc_pkg::MaxProcs];
    logic [swtc_pkg::TimeW-1:0] elapsed;
    int unsigned                i, j, swap;
    proc_times_t                pt;
    elapsed = '0;
    for (i = 0; i < batch_len; i++) run_order[i] = i;
    for (i = 0; i + 1 < batch_len; i++) begin
      for (j = i + 1; j < batch_len; j++) begin
        if (batch_bursts[run_order[i]] > batch_bursts[run_order[j]]) begin
          swap         = run_order[i];
          run_order[i] = run_order[j];
          run_order[j] = swap;
        end
      end
    end
    for (i = 0; i < batch_len; i++) begin
      start_at[run_order[i]] = elapsed;
      elapsed = elapsed + swtc_pkg::TimeW'(batch_bursts[run_order[i]]);
    end
    for (i = 0; i < batch_len; i++) begin
      pt.proc_idx   = swtc_pkg::IdxW'(i);
      pt.wait_tm    = start_at[i];
      pt.turnaround = start_at[i] + swtc_pkg::TimeW'(batch_bursts[i]);
      pt.last_res   = (i + 1 == batch_len);
      sched_times_q.push_back(pt);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    proc_times_t got, want;
    if (!rst_ni) begin
      batch_len = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (batch_len < swtc_pkg::MaxProcs) begin
          batch_bursts[batch_len] = s_axis_tdata;
          batch_len++;
        end
        if (s_axis_tlast) begin
          schedule_batch_times();
          batch_len = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.proc_idx   = m_axis_tdata[4:0];
        got.wait_tm    = m_axis_tdata[25:5];
        got.turnaround = m_axis_tdata[46:26];
        got.last_res   = m_axis_tlast;
        if (sched_times_q.size() == 0) begin
          $error("result word with nothing expected: process_index %0d", got.proc_idx);
          fails++;
        end else begin
          want = sched_times_q.pop_front();
          check_field("process_index", want.proc_idx, got.proc_idx);
          check_field("wait_time", want.wait_tm, got.wait_tm);
          check_field("turnaround_time", want.turnaround, got.turnaround);
          check_field("last_result", want.last_res, got.last_res);
        end
      end
    end
    pending = sched_times_q.size();
  end

endmodule

// ----- tb/sjf_wait_turnaround_calc_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_wait_turnaround_calc_top_tb
// Drives batches of burst words into the SJF calculator: a few directed
// batches (single process, extremes, ties), then random batches of mixed
// size up to and past capacity, with random gaps on both sides, a long sink
// hold-off and quiet stretches. The checker predicts and compares.
// ----------------------------------------------------------------------------
module sjf_wait_turnaround_calc_top_tb;

  localparam int unsigned Items      = 370;
  localparam int unsigned HoldCycles = 600;

  typedef enum int unsigned {
    MIX_RANDOM,
    MIX_TIES,
    MIX_EDGES,
    MIX_ALL_MAX
  } burst_mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] burst_time
  logic        s_axis_tlast;   // last_process
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [4:0] index, [25:5] wait, [46:26] turnaround
  logic        m_axis_tlast;   // last_result

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_sent;
  bit          tx_idle_en;
  bit          rx_hold_req;
  logic [15:0] batch_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sjf_wait_turnaround_calc_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  sjf_wait_turnaround_calc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic logic [15:0] pick_burst(burst_mix_e mix);
    case (mix)
      MIX_RANDOM: return 16'($urandom);
      MIX_TIES:   return 16'($urandom_range(7));
      MIX_EDGES:  return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default:    return 16'hFFFF;
    endcase
  endfunction

  task automatic send_word(input logic [15:0] burst, input logic is_last);
    while (tx_idle_en && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= burst;
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_batch();
    int unsigned k;
    for (k = 0; k < batch_q.size(); k++) begin
      tx_idle_en = !(words_sent >= 140 && words_sent < 220);
      if (words_sent >= 100) rx_hold_req = 1'b1;
      send_word(batch_q[k], k + 1 == batch_q.size());
      if (k < swtc_pkg::MaxProcs) words_sent++;
    end
  endtask

  // sink: random stalls, one long hold-off, one stall-free stretch
  initial begin
    int unsigned cyc, hold_left;
    bit          hold_done;
    cyc           = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (cyc >= 2000 && cyc < 5000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin
    int unsigned len, r;
    burst_mix_e  mix;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_idle_en    = 1'b1;
    rx_hold_req   = 1'b0;
    words_sent    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    batch_q = '{16'hFFFF};
    send_batch();
    batch_q = '{16'h0000};
    send_batch();
    batch_q = '{16'd7, 16'd7};
    send_batch();
    batch_q = '{16'd5, 16'd3, 16'd5, 16'd1, 16'd3, 16'h0000, 16'hFFFF, 16'd1};
    send_batch();
    batch_q = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};
    send_batch();

    while (words_sent < Items) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(8, 1);
      else if (r < 85) len = $urandom_range(20, 9);
      else if (r < 93) len = swtc_pkg::MaxProcs;
      else len = $urandom_range(swtc_pkg::MaxProcs + 4, swtc_pkg::MaxProcs + 1);
      mix = burst_mix_e'($urandom_range(MIX_ALL_MAX));
      batch_q.delete();
      repeat (len) batch_q.push_back(pick_burst(mix));
      send_batch();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/swtc_pkg.sv
rtl/swtc_ram.sv
rtl/sjf_wait_turnaround_calc_top.sv
tb/sjf_wait_turnaround_calc_checker.sv
tb/sjf_wait_turnaround_calc_top_tb.sv
